// ===== rtl/hbs_pkg.sv =====
// Shared types and constants for the height map bilinear sampler.
// No dependencies; every other file in rtl/ imports this package.
`timescale 1ns / 1ps

package hbs_pkg;

    // Store geometry and register reset values
    localparam int HBS_MAP_DIM       = 256;
    localparam int CELL_SIZE_RST     = 150;
    localparam int HEIGHT_SCALE_RST  = 7680;
    localparam int MAP_DIM_RST       = 256;

    // Divider: the coordinate in Q24.8 shifted up by 8, non-negative part only
    localparam int DIV_NUM_W         = 39;
    localparam int DIV_CNT_W         = 6;

    // Register widths
    localparam int CELL_W            = 16;
    localparam int SCALE_W           = 24;
    localparam int DIMREG_W          = 9;
    localparam int CFG_DATA_W        = 24;
    localparam int CFG_ADDR_W        = 2;

    // Multiply-accumulate widths
    localparam int MAC_A_W           = 40;
    localparam int MAC_B_W           = 17;
    localparam int MAC_ACC_W         = 64;

    // Command codes
    localparam logic CMD_LOAD  = 1'b0;
    localparam logic CMD_QUERY = 1'b1;

    // Register indexes
    localparam logic [CFG_ADDR_W-1:0] CFG_CELL_SIZE    = 2'd0;
    localparam logic [CFG_ADDR_W-1:0] CFG_HEIGHT_SCALE = 2'd1;
    localparam logic [CFG_ADDR_W-1:0] CFG_MAP_WIDTH    = 2'd2;
    localparam logic [CFG_ADDR_W-1:0] CFG_MAP_HEIGHT   = 2'd3;

    // Control of the shared multiply-accumulate unit
    typedef struct packed {
        logic en;     // update the accumulator
        logic add;    // add the product to the accumulator, else load it
        logic shl12;  // shift the product left by 12 before use
    } t_mac_ctl;

endpackage

// ===== rtl/heightmap_bilinear_sampler.sv =====
// Top level of the height map bilinear sampler: registers, sequencer, outputs.
// Depends on hbs_pkg, hbs_divider, hbs_store and hbs_mac.
`timescale 1ns / 1ps
//
//  Channel   Direction  Handshake                Payload
//  item      in         start && !busy           i_cmd, i_load_*, i_point_x, i_point_y
//  result    out        o_valid (one cycle)      o_surface_height, o_in_range
//  config    in         i_cfg_we                 i_cfg_addr, i_cfg_wdata
//
//  A load writes the store and busy stays low. A query holds busy while it computes
//  the 39 quotient bits of x and y together and flags done, reads the corners
//  through the one read port, blends them on the shared multiply-add and registers
//  the result. The strobe rises as busy falls. A negative point skips all but the
//  last of these steps, one off the map the reads and the blend. Synchronous reset
//  restores register defaults, not the memory; the receiver cannot stall the strobe.

module heightmap_bilinear_sampler import hbs_pkg::*; #(
    parameter int MAP_DIM = HBS_MAP_DIM
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    start,
    output logic                    busy,
    input  logic                    i_cmd,
    input  logic [7:0]              i_load_col,
    input  logic [7:0]              i_load_row,
    input  logic [7:0]              i_load_value,
    input  logic signed [31:0]      i_point_x,
    input  logic signed [31:0]      i_point_y,
    output logic                    o_valid,
    output logic [39:0]             o_surface_height,
    output logic                    o_in_range,
    input  logic                    i_cfg_we,
    input  logic [CFG_ADDR_W-1:0]   i_cfg_addr,
    input  logic [CFG_DATA_W-1:0]   i_cfg_wdata
);

    localparam int CW = $clog2(MAP_DIM);
    localparam int AW = 2 * CW;

    typedef enum logic [4:0] {
        S_IDLE = 5'b00001,
        S_DIV  = 5'b00010,
        S_READ = 5'b00100,
        S_MAC  = 5'b01000,
        S_FIN  = 5'b10000
    } t_state;

    t_state                 r_state;
    t_state                 n_state;

    logic [CELL_W-1:0]      r_cell_size;
    logic [SCALE_W-1:0]     r_height_scale;
    logic [DIMREG_W-1:0]    r_map_width;
    logic [DIMREG_W-1:0]    r_map_height;

    logic                   r_ok;
    logic [DIMREG_W-1:0]    r_ix;
    logic [DIMREG_W-1:0]    r_iy;
    logic [DIMREG_W-1:0]    r_ix1;
    logic [DIMREG_W-1:0]    r_iy1;
    logic [15:0]            r_fx;
    logic [15:0]            r_fy;
    logic [2:0]             r_rd_cnt;
    logic [7:0]             r_h [4];
    logic [2:0]             r_step;
    logic [23:0]            r_low;
    logic [23:0]            r_high;
    logic [39:0]            r_blend;

    logic                   r_valid;
    logic [39:0]            r_surface_height;
    logic                   r_in_range;

    logic                   accept;
    logic                   load_we;
    logic                   neg_point;
    logic [CELL_W-1:0]      cs_eff;
    logic [DIMREG_W-1:0]    w_eff;
    logic [DIMREG_W-1:0]    h_eff;

    logic                   div_start;
    logic                   div_done;
    logic [DIV_NUM_W-1:0]   quo_x;
    logic [DIV_NUM_W-1:0]   quo_y;
    logic [22:0]            cell_x;
    logic [22:0]            cell_y;
    logic                   on_map;
    logic [DIMREG_W:0]      ix_inc;
    logic [DIMREG_W:0]      iy_inc;

    logic [AW-1:0]          waddr;
    logic [AW-1:0]          raddr;
    logic [7:0]             rdata;
    logic [DIMREG_W-1:0]    rd_col;
    logic [DIMREG_W-1:0]    rd_row;

    t_mac_ctl               mac_ctl;
    logic [MAC_A_W-1:0]     mac_a;
    logic [MAC_B_W-1:0]     mac_b;
    logic [MAC_ACC_W-1:0]   mac_acc;

    // Accept and decode the item
    assign accept    = start && !busy;
    assign neg_point = i_point_x[31] || i_point_y[31];
    assign load_we   = accept && (i_cmd == CMD_LOAD)
                       && (32'(i_load_col) < MAP_DIM) && (32'(i_load_row) < MAP_DIM);
    assign div_start = accept && (i_cmd == CMD_QUERY) && !neg_point;
    assign busy      = (r_state != S_IDLE);

    // Effective configuration: zero cell size acts as one, map size clamps to the store
    assign cs_eff = (r_cell_size == '0) ? CELL_W'(1) : r_cell_size;
    assign w_eff  = (32'(r_map_width)  > MAP_DIM) ? DIMREG_W'(MAP_DIM) : r_map_width;
    assign h_eff  = (32'(r_map_height) > MAP_DIM) ? DIMREG_W'(MAP_DIM) : r_map_height;

    // Configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cell_size    <= CELL_W'(CELL_SIZE_RST);
            r_height_scale <= SCALE_W'(HEIGHT_SCALE_RST);
            r_map_width    <= DIMREG_W'(MAP_DIM_RST);
            r_map_height   <= DIMREG_W'(MAP_DIM_RST);
        end else if (i_cfg_we) begin
            case (i_cfg_addr)
                CFG_CELL_SIZE:    r_cell_size    <= i_cfg_wdata[CELL_W-1:0];
                CFG_HEIGHT_SCALE: r_height_scale <= i_cfg_wdata[SCALE_W-1:0];
                CFG_MAP_WIDTH:    r_map_width    <= i_cfg_wdata[DIMREG_W-1:0];
                CFG_MAP_HEIGHT:   r_map_height   <= i_cfg_wdata[DIMREG_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // Cell index and fraction: quotient of (coordinate << 8) by the cell size
    hbs_divider u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_num_x ({i_point_x[30:0], 8'b0}),
        .i_num_y ({i_point_y[30:0], 8'b0}),
        .i_den   (cs_eff),
        .o_done  (div_done),
        .o_quo_x (quo_x),
        .o_quo_y (quo_y)
    );

    assign cell_x = quo_x[DIV_NUM_W-1:16];
    assign cell_y = quo_y[DIV_NUM_W-1:16];
    assign on_map = (cell_x < 23'(w_eff)) && (cell_y < 23'(h_eff));
    assign ix_inc = {1'b0, cell_x[DIMREG_W-1:0]} + 1'b1;
    assign iy_inc = {1'b0, cell_y[DIMREG_W-1:0]} + 1'b1;

    // Corner reads in order: (ix,iy) (ix1,iy) (ix,iy1) (ix1,iy1)
    always_comb begin
        rd_col = r_rd_cnt[0] ? r_ix1 : r_ix;
        rd_row = r_rd_cnt[1] ? r_iy1 : r_iy;
    end

    assign waddr = {CW'(i_load_row), CW'(i_load_col)};
    assign raddr = {CW'(rd_row), CW'(rd_col)};

    hbs_store #(
        .MAP_DIM (MAP_DIM)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (load_we),
        .i_waddr (waddr),
        .i_wdata (i_load_value),
        .i_raddr (raddr),
        .o_rdata (rdata)
    );

    // Blend schedule on the shared multiply-accumulate
    always_comb begin
        mac_ctl = '{en: (r_state == S_MAC), add: r_step[0], shl12: 1'b0};
        mac_a   = '0;
        mac_b   = '0;
        case (r_step)
            3'd0: begin
                mac_a = MAC_A_W'(r_h[0]);
                mac_b = 17'h10000 - {1'b0, r_fx};
            end
            3'd1: begin
                mac_a = MAC_A_W'(r_h[1]);
                mac_b = {1'b0, r_fx};
            end
            3'd2: begin
                mac_a = MAC_A_W'(r_h[2]);
                mac_b = 17'h10000 - {1'b0, r_fx};
            end
            3'd3: begin
                mac_a = MAC_A_W'(r_h[3]);
                mac_b = {1'b0, r_fx};
            end
            3'd4: begin
                mac_a = MAC_A_W'(r_low);
                mac_b = 17'h10000 - {1'b0, r_fy};
            end
            3'd5: begin
                mac_a = MAC_A_W'(r_high);
                mac_b = {1'b0, r_fy};
            end
            3'd6: begin
                mac_a = mac_acc[MAC_A_W-1:0];
                mac_b = MAC_B_W'(r_height_scale[11:0]);
            end
            3'd7: begin
                mac_a         = r_blend;
                mac_b         = MAC_B_W'(r_height_scale[23:12]);
                mac_ctl.shl12 = 1'b1;
            end
            default: begin
            end
        endcase
    end

    hbs_mac u_mac (
        .i_clk (i_clk),
        .i_ctl (mac_ctl),
        .i_a   (mac_a),
        .i_b   (mac_b),
        .o_acc (mac_acc)
    );

    // Next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (accept && (i_cmd == CMD_QUERY)) begin
                    n_state = neg_point ? S_FIN : S_DIV;
                end
            end
            S_DIV: begin
                if (div_done) begin
                    n_state = on_map ? S_READ : S_FIN;
                end
            end
            S_READ: begin
                if (r_rd_cnt == 3'd4) begin
                    n_state = S_MAC;
                end
            end
            S_MAC: begin
                if (r_step == 3'd7) begin
                    n_state = S_FIN;
                end
            end
            S_FIN:   n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_valid <= (r_state == S_FIN);
        end
    end

    // Query datapath: latch cell, gather corners, hold blend partials, register the result
    always_ff @(posedge i_clk) begin
        case (r_state)
            S_IDLE: begin
                r_ok     <= 1'b0;
                r_rd_cnt <= '0;
                r_step   <= '0;
            end
            S_DIV: begin
                r_ok  <= on_map;
                r_ix  <= cell_x[DIMREG_W-1:0];
                r_iy  <= cell_y[DIMREG_W-1:0];
                r_ix1 <= (ix_inc < {1'b0, w_eff}) ? ix_inc[DIMREG_W-1:0]
                                                  : cell_x[DIMREG_W-1:0];
                r_iy1 <= (iy_inc < {1'b0, h_eff}) ? iy_inc[DIMREG_W-1:0]
                                                  : cell_y[DIMREG_W-1:0];
                r_fx  <= quo_x[15:0];
                r_fy  <= quo_y[15:0];
            end
            S_READ: begin
                r_rd_cnt <= r_rd_cnt + 1'b1;
                if (r_rd_cnt != '0) begin
                    r_h[2'(r_rd_cnt - 3'd1)] <= rdata;
                end
            end
            S_MAC: begin
                r_step <= r_step + 1'b1;
                if (r_step == 3'd2) begin
                    r_low <= mac_acc[23:0];
                end
                if (r_step == 3'd4) begin
                    r_high <= mac_acc[23:0];
                end
                if (r_step == 3'd6) begin
                    r_blend <= mac_acc[MAC_A_W-1:0];
                end
            end
            S_FIN: begin
                r_surface_height <= r_ok ? {8'b0, mac_acc[63:32]} : '0;
                r_in_range       <= r_ok;
            end
            default: begin
            end
        endcase
    end

    assign o_valid          = r_valid;
    assign o_surface_height = r_surface_height;
    assign o_in_range       = r_in_range;

`ifndef SYNTHESIS
    a_load_no_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && (i_cmd == CMD_LOAD)) |=> !busy)
        else $error("load item raised busy");

    a_query_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && (i_cmd == CMD_QUERY)) |=> busy)
        else $error("query item not taken into work");

    a_result_after_work: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> ($past(r_state) == S_FIN))
        else $error("result strobe without finishing a query");

    a_off_map_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_in_range) |-> (o_surface_height == '0))
        else $error("off-map result carries a height");

    a_div_done_in_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_done |-> (r_state == S_DIV))
        else $error("divider finished outside the divide phase");
`endif

endmodule

// ===== rtl/hbs_divider.sv =====
// Dual bit-serial restoring divider: x and y quotients by one shared divisor.
// Depends on hbs_pkg for the dividend and counter widths.
`timescale 1ns / 1ps

module hbs_divider import hbs_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_start,
    input  logic [DIV_NUM_W-1:0]  i_num_x,
    input  logic [DIV_NUM_W-1:0]  i_num_y,
    input  logic [CELL_W-1:0]     i_den,
    output logic                  o_done,
    output logic [DIV_NUM_W-1:0]  o_quo_x,
    output logic [DIV_NUM_W-1:0]  o_quo_y
);

    localparam logic [DIV_CNT_W-1:0] LAST_STEP = DIV_CNT_W'(DIV_NUM_W - 1);

    logic                  r_busy;
    logic                  r_done;
    logic [DIV_CNT_W-1:0]  r_cnt;
    logic [CELL_W-1:0]     r_den;
    logic [CELL_W-1:0]     r_rem_x;
    logic [CELL_W-1:0]     r_rem_y;
    logic [DIV_NUM_W-1:0]  r_quo_x;
    logic [DIV_NUM_W-1:0]  r_quo_y;
    logic [CELL_W-1:0]     n_rem_x;
    logic [CELL_W-1:0]     n_rem_y;
    logic                  n_bit_x;
    logic                  n_bit_y;

    // One restoring step: shift in the next dividend bit, subtract if it fits
    function automatic logic [CELL_W:0] div_step(input logic [CELL_W-1:0] rem,
                                                 input logic              nbit,
                                                 input logic [CELL_W-1:0] den);
        logic [CELL_W:0] sh;
        logic [CELL_W:0] dif;
        sh  = {rem, nbit};
        dif = sh - {1'b0, den};
        if (sh >= {1'b0, den}) begin
            div_step = {1'b1, dif[CELL_W-1:0]};
        end else begin
            div_step = {1'b0, sh[CELL_W-1:0]};
        end
    endfunction

    always_comb begin
        {n_bit_x, n_rem_x} = div_step(r_rem_x, r_quo_x[DIV_NUM_W-1], r_den);
        {n_bit_y, n_rem_y} = div_step(r_rem_y, r_quo_y[DIV_NUM_W-1], r_den);
    end

    // Control: count one quotient bit per cycle
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start && !r_busy) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == LAST_STEP) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // Datapath: dividend bits shift out as quotient bits shift in
    always_ff @(posedge i_clk) begin
        if (i_start && !r_busy) begin
            r_den   <= i_den;
            r_rem_x <= '0;
            r_rem_y <= '0;
            r_quo_x <= i_num_x;
            r_quo_y <= i_num_y;
        end else if (r_busy) begin
            r_rem_x <= n_rem_x;
            r_rem_y <= n_rem_y;
            r_quo_x <= {r_quo_x[DIV_NUM_W-2:0], n_bit_x};
            r_quo_y <= {r_quo_y[DIV_NUM_W-2:0], n_bit_y};
        end
    end

    assign o_done  = r_done;
    assign o_quo_x = r_quo_x;
    assign o_quo_y = r_quo_y;

endmodule

// ===== rtl/hbs_store.sv =====
// Height sample memory: one write port, one registered read port.
// Depends on hbs_pkg only through the default map dimension.
`timescale 1ns / 1ps

module hbs_store import hbs_pkg::*; #(
    parameter int MAP_DIM = HBS_MAP_DIM
) (
    input  logic                            i_clk,
    input  logic                            i_we,
    input  logic [2*$clog2(MAP_DIM)-1:0]    i_waddr,
    input  logic [7:0]                      i_wdata,
    input  logic [2*$clog2(MAP_DIM)-1:0]    i_raddr,
    output logic [7:0]                      o_rdata
);

    localparam int AW = 2 * $clog2(MAP_DIM);

    logic [7:0] r_mem [2**AW];
    logic [7:0] r_rdata;

    // Write a loaded sample; the read data is registered
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== rtl/hbs_mac.sv =====
// Shared multiply-accumulate unit for the bilinear blend and height scaling.
// Depends on hbs_pkg for t_mac_ctl and the operand widths.
`timescale 1ns / 1ps

module hbs_mac import hbs_pkg::*; (
    input  logic                  i_clk,
    input  t_mac_ctl              i_ctl,
    input  logic [MAC_A_W-1:0]    i_a,
    input  logic [MAC_B_W-1:0]    i_b,
    output logic [MAC_ACC_W-1:0]  o_acc
);

    logic [MAC_A_W+MAC_B_W-1:0] prod;
    logic [MAC_ACC_W-1:0]       prod_sh;
    logic [MAC_ACC_W-1:0]       r_acc;

    // Form the product, optionally weighted by 2^12
    always_comb begin
        prod = i_a * i_b;
        if (i_ctl.shl12) begin
            prod_sh = MAC_ACC_W'(prod) << 12;
        end else begin
            prod_sh = MAC_ACC_W'(prod);
        end
    end

    // Load or accumulate
    always_ff @(posedge i_clk) begin
        if (i_ctl.en) begin
            r_acc <= i_ctl.add ? (r_acc + prod_sh) : prod_sh;
        end
    end

    assign o_acc = r_acc;

endmodule
